>>> design/sha256_byte_stream_hash_assert.svh
// Assertion macros shared by the SHA-256 stream hash RTL.
`ifndef SHA256_BYTE_STREAM_HASH_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASH_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/sha_pkg.sv
// Package with SHA-256 constants, types and helper functions.
`default_nettype none
package sha_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int LEN_POS = 56;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int ROUNDS = 64;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PAD  = 6'b000010,
        ST_LOAD = 6'b000100,
        ST_RND  = 6'b001000,
        ST_ADD  = 6'b010000,
        ST_OUT  = 6'b100000
    } sha_state_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage
`default_nettype wire

>>> design/sha_stream_if.sv
// Valid/ready stream interface carrying one payload type.
`default_nettype none
interface sha_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> design/sha256_byte_stream_hash.sv
// SHA-256 hash of a byte stream: top level with one shared round unit.
//
// Bytes (mode 0) are taken one per transaction: the byte is written into a
// 64-entry byte RAM in the accepting cycle, and the busy register then holds
// the input off. The transaction that carries the 64th byte of a block starts
// a compression, which holds the input off while it runs. Its load phase reads
// the sixteen message words from the RAM one byte per cycle, through the RAM's
// registered read. The 64 rounds then run in turn on the shared round unit,
// with the schedule kept in a 16-word sliding window. The ADD state then adds
// the working variables into the chaining state. A finish transaction (mode 1)
// writes 0x80 in its accepting cycle. It then writes zero and length padding
// one byte a cycle up to the end of the block, followed by a compression.
// When 56 or more bytes were buffered, a second padded block follows, which
// costs another padding pass and another compression. The block then
// delivers eight digest transactions, word 0 first, with last_word set on
// word 7, one per cycle at best while the sink is ready. After the eighth word
// it returns to the initial hash value with empty counts. No reset pass is
// needed: every buffer byte is written before read.
`default_nettype none
`include "sha256_byte_stream_hash_assert.svh"
module sha256_byte_stream_hash
    import sha_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    sha_stream_if.sink   in_stream,
    sha_stream_if.source out_stream
);
    sha_state_t  state_reg, state_next;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [6:0]  cnt_reg;       // load byte counter / round counter / pad pointer
    logic        fin_reg;       // compressing as part of a finish
    logic        two_reg;       // a second padded block still follows
    logic        rd_pend_reg;   // RAM read data valid for the load
    logic [2:0]  oidx_reg;
    logic        busy_reg;      // holds the input off after an accepted transaction

    logic        ram_we;
    logic [5:0]  ram_addr;
    logic [7:0]  ram_wdata;
    logic [7:0]  ram_rdata;

    sha_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    logic        in_fire;
    logic        blk_done;
    logic        out_last;
    logic [31:0] t1, t2, w_new;

    assign in_stream.ready = (state_reg == ST_IDLE) && !busy_reg;
    assign in_fire = in_stream.valid && in_stream.ready;
    assign blk_done = in_fire && !in_stream.payload.mode && (fill_reg == 6'd63);
    assign out_last = out_stream.valid && out_stream.ready && (oidx_reg == 3'd7);

    assign out_stream.valid = (state_reg == ST_OUT);
    assign out_stream.payload.digest_word = h_reg[oidx_reg];
    assign out_stream.payload.word_index = oidx_reg;
    assign out_stream.payload.last_word = (oidx_reg == 3'd7);

    // Round unit: schedule word w_reg[0] is used this round.
    assign t1 = v_reg[7] + bsig1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + ROUND_K[cnt_reg[5:0]] + w_reg[0];
    assign t2 = bsig0(v_reg[0]) + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2])
              ^ (v_reg[1] & v_reg[2]));
    assign w_new = sig1(w_reg[14]) + w_reg[9] + sig0(w_reg[1]) + w_reg[0];

    // Padding byte at pad pointer cnt_reg: length bytes in the last eight.
    logic [7:0] pad_byte;
    always_comb
    begin
        pad_byte = 8'h00;
        if (cnt_reg[5:0] >= 6'(LEN_POS) && !two_reg)
        begin
            pad_byte = len_reg[8'(7'd63 - cnt_reg) * 8 +: 8];
        end
    end

    always_comb
    begin
        ram_we = 1'b0;
        ram_addr = cnt_reg[5:0];
        ram_wdata = pad_byte;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                ram_addr = fill_reg;
                if (in_fire)
                begin
                    ram_we = 1'b1;
                    ram_wdata = in_stream.payload.mode ? PAD_BYTE : in_stream.payload.data_byte;
                    if (in_stream.payload.mode)
                    begin
                        state_next = ST_PAD;
                    end
                    else if (fill_reg == 6'd63)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (cnt_reg[6])
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    ram_we = 1'b1;
                end
            end
            ST_LOAD:
            begin
                if (cnt_reg == 7'd64 && rd_pend_reg)
                begin
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                if (cnt_reg == 7'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (two_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_stream.ready && oidx_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg <= '0;
            len_reg <= '0;
            cnt_reg <= '0;
            fin_reg <= 1'b0;
            two_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            oidx_reg <= '0;
            busy_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INIT_H[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            busy_reg <= in_fire;
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    rd_pend_reg <= 1'b0;
                    if (in_fire)
                    begin
                        if (in_stream.payload.mode)
                        begin
                            fin_reg <= 1'b1;
                            two_reg <= (fill_reg >= 6'(LEN_POS));
                            cnt_reg <= {1'b0, fill_reg} + 7'd1;
                        end
                        else
                        begin
                            fin_reg <= 1'b0;
                            fill_reg <= fill_reg + 6'd1;
                            len_reg <= len_reg + 64'd8;
                        end
                    end
                end
                ST_PAD:
                begin
                    cnt_reg <= cnt_reg[6] ? 7'd0 : cnt_reg + 7'd1;
                    rd_pend_reg <= 1'b0;
                end
                ST_LOAD:
                begin
                    // Address cnt_reg is presented; data for cnt_reg-1 arrives now.
                    rd_pend_reg <= 1'b1;
                    if (rd_pend_reg)
                    begin
                        w_reg[cnt_reg[5:2] - 4'd1 + ((cnt_reg[1:0] == 2'd0) ? 4'd0 : 4'd1)]
                            <= {w_reg[cnt_reg[5:2] - 4'd1
                               + ((cnt_reg[1:0] == 2'd0) ? 4'd0 : 4'd1)][23:0], ram_rdata};
                    end
                    if (cnt_reg == 7'd64)
                    begin
                        if (rd_pend_reg)
                        begin
                            cnt_reg <= '0;
                            for (int i = 0; i < 8; i++)
                            begin
                                v_reg[i] <= h_reg[i];
                            end
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                ST_RND:
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                    for (int i = 0; i < 15; i++)
                    begin
                        w_reg[i] <= w_reg[i + 1];
                    end
                    w_reg[15] <= w_new;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                end
                ST_ADD:
                begin
                    cnt_reg <= '0;
                    two_reg <= 1'b0;
                    oidx_reg <= '0;
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                end
                ST_OUT:
                begin
                    if (out_stream.ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            fin_reg <= 1'b0;
                            fill_reg <= '0;
                            len_reg <= '0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= INIT_H[i];
                            end
                        end
                    end
                end
                default:
                begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    // The input is never ready while a digest waits.
    `SHA_ASSERT_IMP(a_no_in_during_out, clk, rst_n, out_stream.valid, !in_stream.ready, "in ready")
    // An absorb that completes a block starts the word load.
    `SHA_ASSERT_NEXT(a_block_load, clk, rst_n, blk_done, state_reg == ST_LOAD, "no load")
    // The final digest word returns the chaining state to the initial value.
    `SHA_ASSERT_NEXT(a_reinit, clk, rst_n, out_last, h_reg[0] == INIT_H[0], "no reinit")
endmodule
`default_nettype wire

>>> design/sha_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module sha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire
